>>> sv/assert_macros.svh
// Assertion macros used by the PS/2 mouse cursor RTL.
// The macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PS2MC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define PS2MC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PS2MC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PS2MC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/ps2mc_pkg.sv
// Types and constants for the PS/2 mouse packet cursor.
// No dependencies; used by every module of the block.
package ps2mc_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned DELTA_W = 9;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAX_X = 1'b0;
    localparam t_cfg_idx CFG_MAX_Y = 1'b1;

    localparam t_coord RESET_MAX_X = 10'd770;
    localparam t_coord RESET_MAX_Y = 10'd570;
    localparam t_coord RESET_POS   = 10'd10;

    typedef struct packed {
        logic   left_button;
        logic   right_button;
        logic   middle_button;
        logic   x_overflow;
        logic   y_overflow;
        t_delta delta_x;
        t_delta delta_y;
    } t_packet;

    typedef struct packed {
        t_packet pkt;
        t_coord  cursor_x;
        t_coord  cursor_y;
    } t_result;

endpackage

>>> sv/ps2mc_assembler.sv
// Byte assembler: syncs on the status byte and gathers three-byte packets.
// Depends on ps2mc_pkg.
module ps2mc_assembler
    import ps2mc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output logic       o_pkt_valid,
    output t_packet    o_pkt
);

    typedef enum logic [1:0] {
        POS_STATUS,
        POS_X,
        POS_Y
    } t_byte_pos;

    t_byte_pos  r_pos;
    t_byte_pos  n_pos;
    logic [7:0] r_status;
    logic [7:0] r_x_byte;
    logic       third;

    always_comb begin
        n_pos = r_pos;
        third = 1'b0;
        unique case (r_pos)
            POS_STATUS: begin
                if (i_data_byte[3]) begin
                    n_pos = POS_X;
                end
            end
            POS_X: begin
                n_pos = POS_Y;
            end
            default: begin
                n_pos = POS_STATUS;
                third = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_STATUS;
            r_status <= 8'd0;
            r_x_byte <= 8'd0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            if (r_pos == POS_STATUS && i_data_byte[3]) begin
                r_status <= i_data_byte;
            end
            if (r_pos == POS_X) begin
                r_x_byte <= i_data_byte;
            end
        end
    end

    assign o_pkt_valid         = i_accept && third;
    assign o_pkt.left_button   = r_status[0];
    assign o_pkt.right_button  = r_status[1];
    assign o_pkt.middle_button = r_status[2];
    assign o_pkt.x_overflow    = r_status[6];
    assign o_pkt.y_overflow    = r_status[7];
    assign o_pkt.delta_x       = {r_status[4], r_x_byte};
    assign o_pkt.delta_y       = {r_status[5], i_data_byte};

endmodule

>>> sv/ps2mc_cursor.sv
// Cursor update: clamps the moved position and holds the result register.
// Also holds the clamp limit registers. Depends on ps2mc_pkg, assert_macros.svh.
`include "assert_macros.svh"
module ps2mc_cursor
    import ps2mc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_coord   i_cfg_data,
    input  logic     i_pkt_valid,
    input  t_packet  i_pkt,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_result  o_result
);

    t_coord              r_max_x;
    t_coord              r_max_y;
    t_coord              r_pos_x;
    t_coord              r_pos_y;
    t_coord              n_pos_x;
    t_coord              n_pos_y;
    logic                r_out_valid;
    t_result             r_result;
    logic signed [11:0]  sum_x;
    logic signed [11:0]  sum_y;

    function automatic t_coord clamp_axis(logic signed [11:0] n, t_coord lim);
        t_coord res;
        if (n[11]) begin
            res = '0;
        end else if (n[10:0] > {1'b0, lim}) begin
            res = lim;
        end else begin
            res = n[9:0];
        end
        return res;
    endfunction

    always_comb begin
        sum_x = $signed({2'b00, r_pos_x}) + $signed({{3{i_pkt.delta_x[8]}}, i_pkt.delta_x});
        sum_y = $signed({2'b00, r_pos_y}) - $signed({{3{i_pkt.delta_y[8]}}, i_pkt.delta_y});
        n_pos_x = i_pkt.x_overflow ? r_pos_x : clamp_axis(sum_x, r_max_x);
        n_pos_y = i_pkt.y_overflow ? r_pos_y : clamp_axis(sum_y, r_max_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= RESET_MAX_X;
            r_max_y <= RESET_MAX_Y;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
                default:   r_max_x <= r_max_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= RESET_POS;
            r_pos_y     <= RESET_POS;
            r_out_valid <= 1'b0;
        end else if (i_pkt_valid) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt_valid) begin
            r_result.pkt      <= i_pkt;
            r_result.cursor_x <= n_pos_x;
            r_result.cursor_y <= n_pos_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `PS2MC_ASSERT(a_pos_x_hold, i_clk, i_rst_n,
        !i_pkt_valid |=> $stable(r_pos_x), "cursor x moved without a packet")
    `PS2MC_ASSERT(a_pos_x_clamp, i_clk, i_rst_n,
        (i_pkt_valid && !i_pkt.x_overflow) |=> (r_pos_x <= $past(r_max_x)),
        "cursor x beyond limit")
    `PS2MC_ASSERT(a_result_follows, i_clk, i_rst_n,
        i_pkt_valid |=> (r_out_valid && r_result.cursor_x == r_pos_x
                         && r_result.cursor_y == r_pos_y),
        "result does not follow packet")

endmodule

>>> sv/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet decoder with clamped cursor.
// Depends on ps2mc_pkg, ps2mc_assembler and ps2mc_cursor.
//
//  channel   dir  width  contents
//  s_axis    in   8      data_byte
//  m_axis    out  48     buttons, overflow flags, deltas, cursor
//  cfg       in   1/10   max_x (index 0), max_y (index 1)
//
// One byte is taken per cycle while tready is high; a result is valid in the
// cycle after a packet's third byte. The single result register sets the rate:
// a byte waits only while that register is full and the downstream side is stalled.
// Synchronous active-low reset; cursor starts at (10, 10), limits at (770, 570).
module ps2_mouse_packet_cursor
    import ps2mc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  t_coord      i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] left_button [1] right_button [2] middle_button [3] x_overflow [4] y_overflow
    // [13:5] delta_x [22:14] delta_y [32:23] cursor_x [42:33] cursor_y [47:43] zero
    output logic [47:0] o_m_axis_tdata
);

    logic    accept;
    logic    pkt_valid;
    t_packet pkt;
    logic    out_valid;
    t_result res;

    assign o_s_axis_tready = !out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    ps2mc_assembler u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .o_pkt_valid (pkt_valid),
        .o_pkt       (pkt)
    );

    ps2mc_cursor u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pkt_valid (pkt_valid),
        .i_pkt       (pkt),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (out_valid),
        .o_result    (res)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {5'd0, res.cursor_y, res.cursor_x,
                              res.pkt.delta_y, res.pkt.delta_x,
                              res.pkt.y_overflow, res.pkt.x_overflow,
                              res.pkt.middle_button, res.pkt.right_button,
                              res.pkt.left_button};

endmodule
